// ===== design/efrx_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the Ethernet
// frame receiver with FCS check. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efrx_pkg;

  // Frame layout and CRC constants
  localparam int          HDR_LEN          = 14;
  localparam int          FCS_LEN          = 4;
  localparam int          PRE_LEN          = 8;
  localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;

  // Configuration defaults and register indexes
  localparam int          MAX_PAYLOAD_DEF  = 2048;
  localparam int          QUEUE_DEPTH_DEF  = 4;
  localparam logic [11:0] PAYLOAD_LEN_RST  = 12'd46;
  localparam logic [63:0] PREAMBLE_RST     = 64'hABAA_AAAA_AAAA_AAAA;
  localparam logic        REG_PAYLOAD_LEN  = 1'b0;
  localparam logic        REG_PREAMBLE     = 1'b1;

  // Receive phase of the front end
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_FCS  = 2'd2
  } phase_t;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_HDR      = 2'd0,  // CRC only
    OP_PAY      = 2'd1,  // CRC and pass out
    OP_FCS      = 2'd2,  // collect one FCS byte
    OP_FCS_LAST = 2'd3   // collect last FCS byte, report status
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  lane;
    logic [7:0]  data;
  } efrx_op_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = (c >> 1) ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/ethernet_frame_receiver_fcs_check_unit.sv =====
// Ethernet frame receiver with FCS check, top level.
// Instantiates efrx_front, efrx_queue and efrx_back; depends on efrx_pkg.
//
// Usage:
//   Received bytes enter on the s_ stream, one per accepted request. The
//   front end hunts the configured preamble/SFD, then classifies 14 header
//   bytes, payload_length payload bytes and 4 FCS bytes (LSB first).
//   Results leave on the m_ stream: one item per payload byte, and one
//   status item after the last FCS byte with the good/bad flag and the
//   computed CRC-32 (reflected, init all ones, final invert). Downstream
//   drops the frame on a bad status.
//   A payload byte accepted on s_ is queued, popped into the output
//   register and shown on m_. Throughput: one byte per cycle when
//   m_tready is high, limited by the back end's single-byte CRC update.
//   Reset clears the phase to hunting, the CRC to all ones, the queue and
//   the output valid flag; configuration returns to 46 bytes and the
//   standard preamble. When m_tready is low the output register holds,
//   the queue (QUEUE_DEPTH requests) fills, and s_tready then drops.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and the user makes them while no frame is in progress; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_frame_receiver_fcs_check_unit #(
  parameter int MAX_PAYLOAD = efrx_pkg::MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = efrx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data_byte[7:0], computed_fcs[39:8]
  output logic [1:0]       m_tuser    // is_status[0], fcs_good[1]
);
  import efrx_pkg::*;

  logic     push;
  efrx_op_t push_op;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  efrx_op_t q_op;

  efrx_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .push      (push),
    .push_op   (push_op),
    .q_full    (q_full)
  );

  efrx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  efrx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== design/efrx_front.sv =====
// Front end: holds configuration, hunts the preamble and classifies frame
// bytes into queue requests. Depends on efrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efrx_front #(
  parameter int MAX_PAYLOAD = efrx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [63:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  output logic                  push,
  output efrx_pkg::efrx_op_t    push_op,
  input  wire logic             q_full
);
  import efrx_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + HDR_LEN + 1);

  logic [11:0]      payload_length;
  logic [63:0]      preamble_pattern;
  phase_t           phase, phase_next;
  logic [2:0]       hunt_match, hunt_match_next;
  logic [CNT_W-1:0] byte_index, byte_index_next;

  logic             accept;
  logic [CNT_W-1:0] eff_len;
  logic [3:0]       match_inc;
  logic [7:0]       pat_byte;
  logic             body_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length   <= PAYLOAD_LEN_RST;
      preamble_pattern <= PREAMBLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAYLOAD_LEN: payload_length   <= cfg_data[11:0];
        REG_PREAMBLE:    preamble_pattern <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Saturate payload length
  always_comb begin
    if ({5'b0, payload_length} > 17'(MAX_PAYLOAD)) eff_len = CNT_W'(MAX_PAYLOAD);
    else                                            eff_len = CNT_W'(payload_length);
  end

  assign pat_byte  = preamble_pattern[{hunt_match, 3'b000} +: 8];
  assign match_inc = {1'b0, hunt_match} + 4'd1;
  assign body_end  = ((CNT_W + 1)'(byte_index) + (CNT_W + 1)'(1))
                     >= ((CNT_W + 1)'(eff_len) + (CNT_W + 1)'(HDR_LEN));

  // Next state
  always_comb begin
    phase_next      = phase;
    hunt_match_next = hunt_match;
    byte_index_next = byte_index;
    unique case (phase)
      PH_BODY: begin
        if (body_end) begin
          phase_next      = PH_FCS;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + CNT_W'(1);
        end
      end
      PH_FCS: begin
        if (byte_index[1:0] == 2'(FCS_LEN - 1)) begin
          phase_next      = PH_HUNT;
          hunt_match_next = '0;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + CNT_W'(1);
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (in_byte == pat_byte) begin
          if (match_inc == 4'(PRE_LEN)) begin
            phase_next      = PH_BODY;
            hunt_match_next = '0;
            byte_index_next = '0;
          end else begin
            hunt_match_next = match_inc[2:0];
          end
        end else begin
          hunt_match_next = (in_byte == preamble_pattern[7:0]) ? 3'd1 : 3'd0;
        end
      end
    endcase
  end

  // Outputs: classify the byte
  always_comb begin
    push         = 1'b0;
    push_op.kind = OP_HDR;
    push_op.lane = byte_index[1:0];
    push_op.data = in_byte;
    unique case (phase)
      PH_BODY: begin
        push         = accept;
        push_op.kind = (byte_index >= CNT_W'(HDR_LEN)) ? OP_PAY : OP_HDR;
      end
      PH_FCS: begin
        push         = accept;
        push_op.kind = (byte_index[1:0] == 2'(FCS_LEN - 1)) ? OP_FCS_LAST : OP_FCS;
      end
      default: ;
    endcase
  end

  // Advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      hunt_match <= '0;
      byte_index <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      hunt_match <= hunt_match_next;
      byte_index <= byte_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/efrx_queue.sv =====
// Short request queue between front and back ends.
// Depends on efrx_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module efrx_queue #(
  parameter int DEPTH = efrx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire efrx_pkg::efrx_op_t push_op,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output efrx_pkg::efrx_op_t    q_op
);
  import efrx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  efrx_op_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = slots[rd_ptr];

  // Store request
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== design/efrx_back.sv =====
// Back end: runs the CRC, collects the received FCS and drives the
// registered result stream. Depends on efrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efrx_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire efrx_pkg::efrx_op_t q_op,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [39:0]           m_tdata,
  output logic [1:0]            m_tuser
);
  import efrx_pkg::*;

  logic [31:0] crc_reg;
  logic [31:0] received_check;
  logic [31:0] crc_upd;
  logic [31:0] fcs_fin;
  logic [31:0] rcv_full;
  logic        makes_out;
  logic        out_free;
  logic        load;

  assign crc_upd   = crc_byte(crc_reg, q_op.data);
  assign fcs_fin   = ~crc_reg;
  assign rcv_full  = {q_op.data, received_check[23:0]};
  assign makes_out = (q_op.kind == OP_PAY) || (q_op.kind == OP_FCS_LAST);
  assign out_free  = !m_tvalid || m_tready;
  assign pop       = q_valid && (!makes_out || out_free);
  assign load      = pop && makes_out;

  // CRC and received FCS
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg        <= CRC_INIT;
      received_check <= '0;
    end else if (pop) begin
      case (q_op.kind) inside
        OP_HDR, OP_PAY: crc_reg <= crc_upd;
        OP_FCS:         received_check[{q_op.lane, 3'b000} +: 8] <= q_op.data;
        OP_FCS_LAST:    crc_reg <= CRC_INIT;
        default:        ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_op.kind == OP_FCS_LAST) begin
        m_tdata <= {fcs_fin, 8'h00};
        m_tuser <= {(rcv_full == fcs_fin), 1'b1};
      end else begin
        m_tdata <= {32'h0, q_op.data};
        m_tuser <= 2'b00;
      end
    end
  end

  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
    else $error("status item carries a data byte");
  a_payload_no_fcs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[39:8] == 32'h0 && !m_tuser[1]))
    else $error("payload item carries status fields");
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && q_op.kind == OP_FCS_LAST) |=> (crc_reg == CRC_INIT))
    else $error("CRC not restarted after status");

endmodule

`default_nettype wire
